>>> hdl/cds_pkg.sv
// ----------------------------------------------------------------------------
// cds_pkg
// Types, constants and calendar helpers shared by the date stepper.
// ----------------------------------------------------------------------------
package cds_pkg;

  localparam int YEAR_BITS  = 16;
  localparam int RES_W      = 5;

  localparam longint unsigned YEAR_MAXV = (64'd1 << YEAR_BITS) - 64'd1;

  // year / 25 by reciprocal: quotient = (year * RECIP_25) >> RECIP_SH
  localparam int RECIP_SH = YEAR_BITS + 5;
  localparam int RECIP_W  = YEAR_BITS + 1;
  localparam int QUO_W    = YEAR_BITS - 4;
  localparam logic [RECIP_W-1:0] RECIP_25 =
    RECIP_W'(((64'd1 << RECIP_SH) + 64'd24) / 64'd25);

  typedef logic [YEAR_BITS-1:0] year_t;
  typedef logic [RES_W-1:0]     res_t;

  // year modulo 25 of the all-ones year, used when stepping back through zero
  localparam res_t RES_WRAP = RES_W'(YEAR_MAXV % 64'd25);
  localparam res_t RES_LAST = RES_W'(24);

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_ADD  = 1'b1;

  localparam logic [3:0] M_JAN = 4'd1;
  localparam logic [3:0] M_FEB = 4'd2;
  localparam logic [3:0] M_APR = 4'd4;
  localparam logic [3:0] M_JUN = 4'd6;
  localparam logic [3:0] M_SEP = 4'd9;
  localparam logic [3:0] M_NOV = 4'd11;
  localparam logic [3:0] M_DEC = 4'd12;

  localparam logic [4:0] D_FIRST = 5'd1;
  localparam logic [4:0] D_28    = 5'd28;
  localparam logic [4:0] D_29    = 5'd29;
  localparam logic [4:0] D_30    = 5'd30;
  localparam logic [4:0] D_31    = 5'd31;

  typedef struct packed {
    logic [4:0] day;
    logic [3:0] month;
    year_t      year;
  } date_t;

  // leap: divisible by 4, and either not by 25 or also by 16
  function automatic logic is_leap(input logic [3:0] y_low, input res_t r25);
    return (y_low[1:0] == 2'd0) && ((r25 != '0) || (y_low == 4'd0));
  endfunction

  function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
    logic [4:0] len;
    len = D_31;
    if (m == M_APR || m == M_JUN || m == M_SEP || m == M_NOV) len = D_30;
    else if (m == M_FEB) len = leap ? D_29 : D_28;
    return len;
  endfunction

  function automatic logic shape_ok(input logic [4:0] d, input logic [3:0] m,
                                    input logic leap);
    return (m >= M_JAN) && (m <= M_DEC) && (d >= D_FIRST) && (d <= month_len(m, leap));
  endfunction

endpackage

>>> hdl/cds_mod25.sv
// ----------------------------------------------------------------------------
// cds_mod25
// Remainder of a year by 25 through a reciprocal multiply, ready in the cycle
// after start.
// ----------------------------------------------------------------------------
module cds_mod25 (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  cds_pkg::year_t value,
  output logic           done,
  output cds_pkg::res_t  rem
);
  import cds_pkg::*;

  logic [2*YEAR_BITS:0] prod;
  logic [QUO_W-1:0]     quo;
  year_t                quo25;
  year_t                diff;

  assign prod  = (2*YEAR_BITS+1)'(value) * (2*YEAR_BITS+1)'(RECIP_25);
  assign quo   = prod[RECIP_SH +: QUO_W];
  assign quo25 = YEAR_BITS'({quo, 4'd0}) + YEAR_BITS'({quo, 3'd0}) + YEAR_BITS'(quo);
  assign diff  = value - quo25;

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= start;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= diff[RES_W-1:0];
    end
  end

endmodule

>>> hdl/cds_step.sv
// ----------------------------------------------------------------------------
// cds_step
// One-day step of a date, forward or back, with the year-mod-25 tracker.
// ----------------------------------------------------------------------------
module cds_step (
  input  cds_pkg::date_t cur,
  input  cds_pkg::res_t  cur_res,
  input  logic           back,
  output cds_pkg::date_t nxt,
  output cds_pkg::res_t  nxt_res
);
  import cds_pkg::*;

  logic       leap;
  logic [4:0] len;
  logic [3:0] prev_m;

  assign leap   = is_leap(cur.year[3:0], cur_res);
  assign len    = month_len(cur.month, leap);
  assign prev_m = cur.month - 1'b1;

  always_comb begin
    nxt     = cur;
    nxt_res = cur_res;
    if (!back) begin
      if (cur.day != len) begin
        nxt.day = cur.day + 1'b1;
      end else if (cur.month != M_DEC) begin
        nxt.day   = D_FIRST;
        nxt.month = cur.month + 1'b1;
      end else begin
        nxt.day   = D_FIRST;
        nxt.month = M_JAN;
        nxt.year  = cur.year + 1'b1;
        if (cur.year == '1)              nxt_res = '0;
        else if (cur_res == RES_LAST)    nxt_res = '0;
        else                             nxt_res = cur_res + 1'b1;
      end
    end else begin
      if (cur.day != D_FIRST) begin
        nxt.day = cur.day - 1'b1;
      end else if (cur.month != M_JAN) begin
        nxt.month = prev_m;
        nxt.day   = month_len(prev_m, leap);
      end else begin
        nxt.year  = cur.year - 1'b1;
        nxt.month = M_DEC;
        nxt.day   = D_31;
        if (cur.year == '0)              nxt_res = RES_WRAP;
        else if (cur_res == '0)          nxt_res = RES_LAST;
        else                             nxt_res = cur_res - 1'b1;
      end
    end
  end

endmodule

>>> hdl/calendar_date_stepper.sv
// ----------------------------------------------------------------------------
// calendar_date_stepper
// Stored Gregorian date with load check and signed day add, one day a cycle.
// ----------------------------------------------------------------------------
// A load passes through the year mod 25 unit (S_MOD), then S_FIN writes the result;
// an add steps one day per cycle through the step unit (S_STEP), then S_FIN,
// and an add on an invalid date goes straight to S_FIN.
// One word in flight; the result register lets the next word be accepted while
// the previous result waits. rst clears the date to 0/0/0.
module calendar_date_stepper (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        cmd,
  input  logic [4:0]  load_day,
  input  logic [3:0]  load_month,
  input  logic [15:0] load_year,
  input  logic signed [15:0] day_delta,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [4:0]  day,
  output logic [3:0]  month,
  output logic [15:0] year,
  output logic        date_valid
);
  import cds_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_MOD  = 4'b0010,
    S_STEP = 4'b0100,
    S_FIN  = 4'b1000
  } state_t;

  state_t      state;
  date_t       cur;
  res_t        cur_res;
  date_t       hold;
  logic [16:0] cnt;
  logic        back;

  date_t       step_d;
  res_t        step_res;
  logic        mod_start;
  logic        mod_done;
  res_t        mod_rem;
  year_t       ld_year;
  logic [31:0] ld_year32;
  logic [31:0] cur_year32;
  logic [16:0] mag;
  logic        cur_ok;
  logic        hold_ok;
  logic        accept;

  assign ld_year32  = {16'd0, load_year};
  assign ld_year    = ld_year32[YEAR_BITS-1:0];
  assign cur_year32 = 32'(cur.year);
  assign mag        = day_delta[15] ? (17'd0 - {day_delta[15], day_delta})
                                    : {1'b0, day_delta};

  assign in_ready  = (state == S_IDLE);
  assign accept    = in_valid && in_ready;
  assign mod_start = accept && (cmd == CMD_LOAD);

  assign cur_ok  = shape_ok(cur.day, cur.month, is_leap(cur.year[3:0], cur_res));
  assign hold_ok = (hold.year != '0) &&
                   shape_ok(hold.day, hold.month, is_leap(hold.year[3:0], mod_rem));

  cds_mod25 u_mod (
    .clk   (clk),
    .rst   (rst),
    .start (mod_start),
    .value (ld_year),
    .done  (mod_done),
    .rem   (mod_rem)
  );

  cds_step u_step (
    .cur     (cur),
    .cur_res (cur_res),
    .back    (back),
    .nxt     (step_d),
    .nxt_res (step_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      cur     <= '0;
      cur_res <= '0;
      cnt     <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            if (cmd == CMD_LOAD) begin
              state <= S_MOD;
            end else if (cur_ok) begin
              cnt   <= mag;
              state <= S_STEP;
            end else begin
              state <= S_FIN;
            end
          end
        end
        S_MOD: begin
          if (mod_done) begin
            cur     <= hold_ok ? hold : '0;
            cur_res <= hold_ok ? mod_rem : '0;
            state   <= S_FIN;
          end
        end
        S_STEP: begin
          if (cnt == '0) begin
            state <= S_FIN;
          end else begin
            cur     <= step_d;
            cur_res <= step_res;
            cnt     <= cnt - 1'b1;
          end
        end
        S_FIN: begin
          if (!out_valid || out_ready) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      hold <= '{day: load_day, month: load_month, year: ld_year};
      back <= day_delta[15];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_FIN && (!out_valid || out_ready)) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_FIN && (!out_valid || out_ready)) begin
      day        <= cur.day;
      month      <= cur.month;
      year       <= cur_year32[15:0];
      date_valid <= (cur.year != '0) && cur_ok;
    end
  end

endmodule

>>> hdl/cds_checker.sv
// ----------------------------------------------------------------------------
// cds_checker
// Port-level checks for the date stepper, bound to the top level.
// ----------------------------------------------------------------------------
module cds_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [4:0]  day,
  input logic [3:0]  month,
  input logic [15:0] year,
  input logic        date_valid
);

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("accepted a word while busy");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(day) && $stable(month) &&
    $stable(year) && $stable(date_valid))
    else $error("result word changed before taken");

  a_valid_shape: assert property (@(posedge clk) disable iff (rst)
    out_valid && date_valid |-> month >= 4'd1 && month <= 4'd12 && day >= 5'd1)
    else $error("valid date with bad month or day");

  a_short_months: assert property (@(posedge clk) disable iff (rst)
    out_valid && date_valid && (month == 4'd4 || month == 4'd6 || month == 4'd9 ||
    month == 4'd11) |-> day <= 5'd30)
    else $error("day past end of a 30-day month");

  a_feb: assert property (@(posedge clk) disable iff (rst)
    out_valid && date_valid && month == 4'd2 |-> day <= 5'd29)
    else $error("day past end of February");

endmodule

bind calendar_date_stepper cds_checker u_cds_checker (.*);
